// ===== src/pocl_pkg.sv =====
// Shared types and constants of the PO catalog lexer.
package pocl_pkg;

  // Byte values that steer the tokenizer.
  localparam logic [7:0] BOM_LEAD  = 8'hEF;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Depth of the command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_KWBYTE  = 3'd0,
    KIND_STRBYTE = 3'd1,
    KIND_KWEND   = 3'd2,
    KIND_STREND  = 3'd3,
    KIND_INEND   = 3'd4
  } kind_t;

  // Lexer modes, one-hot.
  typedef enum logic [9:0] {
    MODE_START   = 10'b00_0000_0001,
    MODE_SKIP2   = 10'b00_0000_0010,
    MODE_SKIP1   = 10'b00_0000_0100,
    MODE_IDLE    = 10'b00_0000_1000,
    MODE_COMMENT = 10'b00_0001_0000,
    MODE_KEYWORD = 10'b00_0010_0000,
    MODE_STRING  = 10'b00_0100_0000,
    MODE_ESCAPE  = 10'b00_1000_0000,
    MODE_AFTER   = 10'b01_0000_0000,
    MODE_AFTCMT  = 10'b10_0000_0000
  } mode_t;

  // One result item without its last flag.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       subst;
    logic       uncl;
  } res_t;

  // Everything one input byte causes: a count of zero to three and the results.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       res;
  } cmd_t;

  // Whitespace: space, tab, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

// ===== src/pocl_front.sv =====
// Front part: runs the lexer state machine and turns each byte into a command.
module pocl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output logic                cmd_push,
  output pocl_pkg::cmd_t      cmd
);
  import pocl_pkg::*;

  mode_t mode_r, mode_nxt;
  mode_t idle_mode;
  logic  idle_emit;
  res_t  kw_res;

  // What a byte does when no token is open.
  always_comb begin
    idle_emit = 1'b0;
    kw_res    = '{kind: KIND_KWBYTE, data: data_byte, subst: 1'b0, uncl: 1'b0};
    priority if (data_byte == CH_HASH) begin
      idle_mode = MODE_COMMENT;
    end else if (is_space(data_byte)) begin
      idle_mode = MODE_IDLE;
    end else if (data_byte == CH_QUOTE) begin
      idle_mode = MODE_STRING;
    end else begin
      idle_mode = MODE_KEYWORD;
      idle_emit = 1'b1;
    end
  end

  // Next mode and the results for the current byte.
  always_comb begin
    res_t inend_res, strend_res, kwend_res, esc_res;
    inend_res  = '{kind: KIND_INEND,  data: 8'h00, subst: 1'b0, uncl: 1'b0};
    strend_res = '{kind: KIND_STREND, data: 8'h00, subst: 1'b0, uncl: 1'b0};
    kwend_res  = '{kind: KIND_KWEND,  data: 8'h00, subst: 1'b0, uncl: 1'b0};
    esc_res    = '{kind: KIND_STRBYTE, data: CH_SPACE, subst: 1'b1, uncl: 1'b0};
    mode_nxt   = mode_r;
    cmd        = '0;
    if (end_of_input) begin
      mode_nxt = MODE_START;
      unique case (mode_r)
        MODE_KEYWORD: begin
          cmd.res[0] = kwend_res;
          cmd.res[1] = inend_res;
          cmd.cnt    = 2'd2;
        end
        MODE_STRING: begin
          cmd.res[0]      = strend_res;
          cmd.res[0].uncl = 1'b1;
          cmd.res[1]      = inend_res;
          cmd.cnt         = 2'd2;
        end
        MODE_ESCAPE: begin
          cmd.res[0]      = esc_res;
          cmd.res[1]      = strend_res;
          cmd.res[1].uncl = 1'b1;
          cmd.res[2]      = inend_res;
          cmd.cnt         = 2'd3;
        end
        MODE_AFTER, MODE_AFTCMT: begin
          cmd.res[0] = strend_res;
          cmd.res[1] = inend_res;
          cmd.cnt    = 2'd2;
        end
        default: begin
          cmd.res[0] = inend_res;
          cmd.cnt    = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_START: begin
          if (data_byte == BOM_LEAD) begin
            mode_nxt = MODE_SKIP2;
          end else begin
            mode_nxt   = idle_mode;
            cmd.res[0] = kw_res;
            cmd.cnt    = {1'b0, idle_emit};
          end
        end
        MODE_SKIP2: mode_nxt = MODE_SKIP1;
        MODE_SKIP1: mode_nxt = MODE_IDLE;
        MODE_COMMENT, MODE_AFTCMT: begin
          if (data_byte == CH_LF) begin
            mode_nxt = (mode_r == MODE_AFTCMT) ? MODE_AFTER : MODE_IDLE;
          end
        end
        MODE_KEYWORD: begin
          if (is_space(data_byte)) begin
            cmd.res[0] = kwend_res;
            mode_nxt   = MODE_IDLE;
          end else begin
            cmd.res[0] = kw_res;
          end
          cmd.cnt = 2'd1;
        end
        MODE_STRING: begin
          priority if (data_byte == CH_QUOTE) begin
            mode_nxt = MODE_AFTER;
          end else if (data_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            cmd.res[0]      = kw_res;
            cmd.res[0].kind = KIND_STRBYTE;
            cmd.cnt         = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          // Known escapes decode, anything else becomes a flagged space.
          cmd.res[0]       = esc_res;
          cmd.res[0].subst = 1'b0;
          unique case (data_byte)
            CH_N:      cmd.res[0].data = CH_LF;
            CH_T:      cmd.res[0].data = CH_TAB;
            CH_R:      cmd.res[0].data = CH_CR;
            CH_QUOTE:  cmd.res[0].data = CH_QUOTE;
            CH_BSLASH: cmd.res[0].data = CH_BSLASH;
            default:   cmd.res[0].subst = 1'b1;
          endcase
          cmd.cnt  = 2'd1;
          mode_nxt = MODE_STRING;
        end
        MODE_AFTER: begin
          priority if (data_byte == CH_QUOTE) begin
            mode_nxt = MODE_STRING;
          end else if (data_byte == CH_HASH) begin
            mode_nxt = MODE_AFTCMT;
          end else if (!is_space(data_byte)) begin
            // A keyword byte straight after a closed string.
            cmd.res[0] = strend_res;
            cmd.res[1] = kw_res;
            cmd.cnt    = 2'd2;
            mode_nxt   = MODE_KEYWORD;
          end
        end
        default: begin
          mode_nxt   = idle_mode;
          cmd.res[0] = kw_res;
          cmd.cnt    = {1'b0, idle_emit};
        end
      endcase
    end
  end

  assign cmd_push = accept && (cmd.cnt != 2'd0);

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  // An input end always leaves the lexer at the start of a file.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_input |=> mode_r == MODE_START)
    else $error("mode not back at start after input end");

  // An input end always produces at least one result.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_input |-> cmd_push)
    else $error("input end without a command");

  // The mode register stays one-hot.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(mode_r))
    else $error("mode register not one-hot");

endmodule

// ===== src/pocl_cmd_queue.sv =====
// Short queue of commands between the front and back parts.
module pocl_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pocl_pkg::cmd_t wr_cmd,
  input  logic           rd_en,
  output pocl_pkg::cmd_t rd_cmd,
  output logic           not_empty,
  output logic           full
);
  import pocl_pkg::*;

  cmd_t                 entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CW-1:0]   count_r, count_nxt;

  assign rd_cmd    = entry_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CMDQ_CW'(CMDQ_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Storage; no reset needed on the payload.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CMDQ_CW'(CMDQ_DEPTH))
    else $error("command queue over-filled");

  assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
    else $error("write into full command queue");

  assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> not_empty)
    else $error("read from empty command queue");

endmodule

// ===== src/pocl_back.sv =====
// Back part: expands each command into result items through an output register.
module pocl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pocl_pkg::cmd_t    head,
  input  logic              head_valid,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output pocl_pkg::res_t    out_res,
  output logic              out_last
);
  import pocl_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  res_t       res_r;
  logic       last_r;
  logic       can_load, load, is_last;

  assign can_load = !valid_r || pop;
  assign load     = can_load && head_valid;
  assign is_last  = (idx_r == head.cnt - 2'd1);
  assign head_pop = load && is_last;

  assign empty    = !valid_r;
  assign out_res  = res_r;
  assign out_last = last_r;

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= head.res[idx_r];
      last_r <= is_last;
    end
  end

  // Control: output valid and position within the current command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < head.cnt)
    else $error("result index beyond command count");

  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.kind == KIND_INEND |-> last_r)
    else $error("input end not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> res_r.kind <= KIND_INEND)
    else $error("invalid result kind");

endmodule

// ===== src/po_catalog_lexer_unit.sv =====
// Top level of the PO catalog lexer.
// Takes one catalog byte, or an end-of-input mark, per transaction and emits
// keyword bytes, string bytes, token ends and an input end, each result with
// a last flag on the final result caused by its input byte. A byte is accepted
// in every cycle while the four-entry command queue between the lexer state
// machine and the result stage has room; results leave one per cycle while
// the receiver pops, so a byte that causes two or three results holds the
// result side for each of them, and the result stage sets the sustained rate.
// Its first result passes through the command queue and the output register.
module po_catalog_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_substituted,
  output logic        out_unclosed,
  output logic        out_last
);
  import pocl_pkg::*;

  logic accept, cmd_push, head_valid, head_pop;
  cmd_t cmd, head;
  res_t res;

  assign accept = push && !full;

  // Lexer state machine.
  pocl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  // Decoupling queue.
  pocl_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd_push),
    .wr_cmd    (cmd),
    .rd_en     (head_pop),
    .rd_cmd    (head),
    .not_empty (head_valid),
    .full      (full)
  );

  // Result stage.
  pocl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_res    (res),
    .out_last   (out_last)
  );

  assign out_kind        = res.kind;
  assign out_out_byte    = res.data;
  assign out_substituted = res.subst;
  assign out_unclosed    = res.uncl;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the PO catalog lexer: random and directed byte streams.
module tb;
  import pocl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 150;

  // One input transaction: a catalog byte or the end-of-input mark.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } catalog_item_t;

  // One result transaction as the lexer should produce it.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       subst;
    logic       uncl;
    logic       last;
  } token_res_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_substituted;
  logic       out_unclosed;
  logic       out_last;

  catalog_item_t catalog_bytes[$];
  token_res_t    pending_tokens[$];
  token_res_t    step_tokens[$];
  mode_t         lex_mode = MODE_START;

  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  po_catalog_lexer_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_substituted (out_substituted),
    .out_unclosed    (out_unclosed),
    .out_last        (out_last)
  );

  // Whitespace as the lexer sees it: space, tab, LF, VT, FF and CR.
  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Queues one result of the current step; the last flag is settled afterwards.
  function automatic void emit(input kind_t k, input logic [7:0] d, input logic s,
                               input logic u);
    token_res_t r;
    r.kind  = k;
    r.data  = d;
    r.subst = s;
    r.uncl  = u;
    r.last  = 1'b0;
    step_tokens = {step_tokens, r};
  endfunction

  // A byte seen while no token is open.
  function automatic void open_token(input logic [7:0] b);
    if (b == CH_HASH) begin
      lex_mode = MODE_COMMENT;
    end else if (is_blank(b)) begin
      lex_mode = MODE_IDLE;
    end else if (b == CH_QUOTE) begin
      lex_mode = MODE_STRING;
    end else begin
      emit(KIND_KWBYTE, b, 1'b0, 1'b0);
      lex_mode = MODE_KEYWORD;
    end
  endfunction

  // Advances the lexer state by one accepted transaction and stores its results.
  function automatic void lex_predict(input catalog_item_t it);
    token_res_t r;
    logic [7:0] b;
    logic [7:0] d;
    logic       s;
    b = it.data;
    if (it.eoi) begin
      case (lex_mode)
        MODE_KEYWORD: emit(KIND_KWEND, 8'h00, 1'b0, 1'b0);
        MODE_STRING:  emit(KIND_STREND, 8'h00, 1'b0, 1'b1);
        MODE_ESCAPE: begin
          emit(KIND_STRBYTE, CH_SPACE, 1'b1, 1'b0);
          emit(KIND_STREND, 8'h00, 1'b0, 1'b1);
        end
        MODE_AFTER, MODE_AFTCMT: emit(KIND_STREND, 8'h00, 1'b0, 1'b0);
        default: ;
      endcase
      emit(KIND_INEND, 8'h00, 1'b0, 1'b0);
      lex_mode = MODE_START;
    end else begin
      case (lex_mode)
        MODE_START: begin
          if (b == BOM_LEAD) lex_mode = MODE_SKIP2;
          else open_token(b);
        end
        MODE_SKIP2: lex_mode = MODE_SKIP1;
        MODE_SKIP1: lex_mode = MODE_IDLE;
        MODE_COMMENT: begin
          if (b == CH_LF) lex_mode = MODE_IDLE;
        end
        MODE_KEYWORD: begin
          if (is_blank(b)) begin
            emit(KIND_KWEND, 8'h00, 1'b0, 1'b0);
            lex_mode = MODE_IDLE;
          end else begin
            emit(KIND_KWBYTE, b, 1'b0, 1'b0);
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) lex_mode = MODE_AFTER;
          else if (b == CH_BSLASH) lex_mode = MODE_ESCAPE;
          else emit(KIND_STRBYTE, b, 1'b0, 1'b0);
        end
        MODE_ESCAPE: begin
          s = 1'b0;
          case (b)
            CH_N:      d = CH_LF;
            CH_T:      d = CH_TAB;
            CH_R:      d = CH_CR;
            CH_QUOTE:  d = CH_QUOTE;
            CH_BSLASH: d = CH_BSLASH;
            default: begin
              d = CH_SPACE;
              s = 1'b1;
            end
          endcase
          emit(KIND_STRBYTE, d, s, 1'b0);
          lex_mode = MODE_STRING;
        end
        MODE_AFTER: begin
          if (b == CH_QUOTE) begin
            lex_mode = MODE_STRING;
          end else if (b == CH_HASH) begin
            lex_mode = MODE_AFTCMT;
          end else if (!is_blank(b)) begin
            emit(KIND_STREND, 8'h00, 1'b0, 1'b0);
            open_token(b);
          end
        end
        MODE_AFTCMT: begin
          if (b == CH_LF) lex_mode = MODE_AFTER;
        end
        default: open_token(b);
      endcase
    end
    // Flag the final result of this transaction and hand all of them on.
    if (step_tokens.size() != 0) begin
      r = step_tokens.pop_back();
      r.last = 1'b1;
      step_tokens = {step_tokens, r};
    end
    while (step_tokens.size() != 0) pending_tokens = {pending_tokens, step_tokens.pop_front()};
  endfunction

  // Compares one field of a result and records a mismatch.
  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  task automatic add(input logic [7:0] b, input logic e);
    catalog_item_t it;
    it.data = b;
    it.eoi  = e;
    catalog_bytes = {catalog_bytes, it};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add(s[i], 1'b0);
  endtask

  task automatic add_end();
    add(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(0, 5) == 5) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  // Any byte but the two given ones.
  function automatic logic [7:0] text_byte(input logic [7:0] x1, input logic [7:0] x2);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x1 || b == x2);
    return b;
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus, reset and end of the run.
  initial begin : p_stimulus
    int unsigned n_dir;
    logic [7:0]  b;

    // A file that ends while the mark bytes are being dropped.
    add(BOM_LEAD, 1'b0);
    add_end();
    // Mark dropped, extreme bytes in a keyword ended by VT, keyword holding '#' and '"'.
    add(BOM_LEAD, 1'b0);
    add(8'hBB, 1'b0);
    add(8'hBF, 1'b0);
    add(8'h00, 1'b0);
    add(8'hFF, 1'b0);
    add(CH_VT, 1'b0);
    add_text("k#\"");
    add_end();
    // Known and unknown escapes, strings joined across a comment, end after a backslash.
    add_text("\"\\n\\q\"#");
    add(CH_LF, 1'b0);
    add_text("\"\\");
    add_end();
    // Remaining escapes, then a keyword straight after a closed string.
    add_text("\"\\t\\r\\\"\\\\\"z");
    add_end();
    n_dir = catalog_bytes.size();

    // Random part: mostly well-formed catalog files, some raw noise.
    while (catalog_bytes.size() < n_dir + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12))
          add(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          add(BOM_LEAD, 1'b0);
          add(8'($urandom_range(0, 255)), 1'b0);
          add(8'($urandom_range(0, 255)), 1'b0);
        end
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: add(blank_byte(), 1'b0);
            1: begin
              add(CH_HASH, 1'b0);
              repeat ($urandom_range(0, 5)) add(text_byte(CH_LF, CH_LF), 1'b0);
              if ($urandom_range(0, 5) != 0) add(CH_LF, 1'b0);
            end
            2: begin
              repeat ($urandom_range(1, 6)) begin
                do begin
                  if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
                  else b = 8'($urandom_range(8'h61, 8'h7A));
                end while (is_blank(b));
                add(b, 1'b0);
              end
              if ($urandom_range(0, 3) != 0) add(blank_byte(), 1'b0);
            end
            default: begin
              // One or more quoted pieces, possibly joined across blanks and comments.
              repeat ($urandom_range(1, 3)) begin
                add(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                  if ($urandom_range(0, 3) == 0) begin
                    add(CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 5))
                      0:       add(CH_N, 1'b0);
                      1:       add(CH_T, 1'b0);
                      2:       add(CH_R, 1'b0);
                      3:       add(CH_QUOTE, 1'b0);
                      4:       add(CH_BSLASH, 1'b0);
                      default: add(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                  end else begin
                    add(text_byte(CH_QUOTE, CH_BSLASH), 1'b0);
                  end
                end
                if ($urandom_range(0, 7) != 0) add(CH_QUOTE, 1'b0);
                else if ($urandom_range(0, 1) == 0) add(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 2))
                  0: ;
                  1: add(blank_byte(), 1'b0);
                  default: begin
                    add(CH_HASH, 1'b0);
                    repeat ($urandom_range(0, 4)) add(text_byte(CH_LF, CH_LF), 1'b0);
                    if ($urandom_range(0, 3) != 0) add(CH_LF, 1'b0);
                  end
                endcase
              end
            end
          endcase
        end
        add_end();
      end
    end
    add_end();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (catalog_bytes.size() != 0) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Sender: offers the queued bytes, with random gaps and gap-free stretches.
  always @(posedge clk) begin : p_send
    if (!rst_n) begin
      push <= 1'b0;
      send_wait = 0;
    end else if (!(push && full)) begin
      // The offered transaction was taken at this edge.
      if (push) begin
        lex_predict(catalog_bytes.pop_front());
        sent_cnt++;
        send_wait = ((sent_cnt / 30) % 3 == 1) ? 0 : $urandom_range(0, 7);
      end
      if (send_wait != 0 || catalog_bytes.size() == 0) begin
        if (send_wait != 0) send_wait--;
        push <= 1'b0;
      end else begin
        push            <= 1'b1;
        in_data_byte    <= catalog_bytes[0].data;
        in_end_of_input <= catalog_bytes[0].eoi;
      end
    end
  end

  // Receiver: takes results, checks them and stalls at random, once for a long stretch.
  always @(posedge clk) begin : p_collect
    token_res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
      take_wait = 0;
      hold_left = 0;
    end else begin
      if (pop && !empty) begin
        taken_cnt++;
        if (pending_tokens.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, actual kind %0d byte %0d",
                   $time, out_kind, out_out_byte);
        end else begin
          want = pending_tokens.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("byte", want.data, out_out_byte);
          check_field("substituted", want.subst, out_substituted);
          check_field("unclosed", want.uncl, out_unclosed);
          check_field("last", want.last, out_last);
        end
        if (taken_cnt == HOLD_AT) hold_left = HOLD_CYCLES;
        else take_wait = ((taken_cnt / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (take_wait != 0) begin
        take_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin : p_watchdog
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule
